// ===== sv/assert_macros.svh =====
// Assertion macros shared by the tile segment projection RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Check that a condition implies a property in the same cycle.
`define ASSERT_IMPLIES(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) else $error(msg);

// Check that a condition implies a property in the next cycle.
`define ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) else $error(msg);

`endif

// ===== sv/tsp_pkg.sv =====
// Types and constants for the tile segment projection block.
package tsp_pkg;

   localparam int COORD_BITS     = 31;
   localparam int WEIGHT_BITS    = 16;
   localparam int PROD_BITS      = 2 * COORD_BITS + WEIGHT_BITS;
   localparam int NUM_BITS       = PROD_BITS + 1;
   localparam int CHUNK_BITS     = 32;
   localparam int NUM_CHUNKS     = (NUM_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
   localparam int FIFO_DEPTH     = 8;
   localparam int CSR_INDEX_BITS = 2;

   typedef logic [COORD_BITS-1:0]     coord_type;
   typedef logic [WEIGHT_BITS-1:0]    weight_type;
   typedef logic [NUM_BITS-1:0]       num_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam csr_index_type CSR_WEIGHT_X = 2'd0;
   localparam csr_index_type CSR_WEIGHT_Y = 2'd1;

   localparam weight_type WEIGHT_X_RESET = WEIGHT_BITS'(12100);
   localparam weight_type WEIGHT_Y_RESET = WEIGHT_BITS'(34708);

   typedef enum logic [1:0] {
      KIND_INTERIOR = 2'd0,
      KIND_START    = 2'd1,
      KIND_END      = 2'd2
   } kind_type;

   typedef struct packed {
      coord_type point_x;
      coord_type point_y;
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
   } req_type;

   typedef struct packed {
      coord_type  proj_x;
      coord_type  proj_y;
      logic [1:0] clamp_kind;
   } rsp_type;

   // Segment endpoints and signed segment deltas
   typedef struct packed {
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
      coord_type dx_mag;
      logic      dx_neg;
      coord_type dy_mag;
      logic      dy_neg;
   } seg_type;

   // Classified transaction passed from front to back
   typedef struct packed {
      seg_type  seg;
      num_type  num;
      num_type  den;
      kind_type kind;
   } job_type;

   typedef struct packed {
      seg_type  seg;
      kind_type kind;
   } meta_type;

endpackage

// ===== sv/tsp_fifo.sv =====
// Job queue between the classification front and the division back.
`include "assert_macros.svh"

module tsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  tsp_pkg::job_type  push_data,
   input  logic              pop,
   output logic              head_valid,
   output tsp_pkg::job_type  head_data
);

   localparam int DEPTH     = tsp_pkg::FIFO_DEPTH;
   localparam int PTR_BITS  = $clog2(DEPTH);
   localparam int CNT_BITS  = $clog2(DEPTH + 1);

   tsp_pkg::job_type    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff;
   logic [PTR_BITS-1:0] rd_ptr_ff;
   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] count_in;

   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];

   // Track occupancy
   always_comb begin
      count_in = count_ff;
      if (push_valid && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (!push_valid && pop) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   // Advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_BITS'(1);
         end
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ASSERT_ALWAYS(a_no_overflow, !(push_valid && !pop && count_ff == CNT_BITS'(DEPTH)), "queue overflow")
   `ASSERT_IMPLIES(a_no_underflow, pop, head_valid, "pop from empty queue")

endmodule

// ===== sv/tsp_front.sv =====
// Front pipeline: deltas, weighted products, numerator and denominator, clamp classification.
`include "assert_macros.svh"

module tsp_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  tsp_pkg::req_type     req_data,
   output logic                 req_stall,
   input  tsp_pkg::weight_type  weight_x,
   input  tsp_pkg::weight_type  weight_y,
   input  logic                 job_pop,
   output logic                 job_valid,
   output tsp_pkg::job_type     job_data
);

   localparam int C         = tsp_pkg::COORD_BITS;
   localparam int W         = tsp_pkg::WEIGHT_BITS;
   localparam int PB        = tsp_pkg::PROD_BITS;
   localparam int NB        = tsp_pkg::NUM_BITS;
   localparam int SQ        = 2 * C;
   localparam int LOW       = 32 + W;
   localparam int WIDE      = 64 + W;
   localparam int USED_BITS = $clog2(tsp_pkg::FIFO_DEPTH + 1);

   logic                 accept;
   logic [USED_BITS-1:0] used_ff;
   logic [USED_BITS-1:0] used_in;

   logic                 s1_vld_ff;
   tsp_pkg::seg_type     s1_seg_ff;
   tsp_pkg::seg_type     s1_seg_in;
   tsp_pkg::coord_type   s1_acx_mag_ff, s1_acy_mag_ff;
   tsp_pkg::coord_type   s1_acx_mag_in, s1_acy_mag_in;
   logic                 s1_acx_neg_ff, s1_acy_neg_ff;
   logic                 s1_acx_neg_in, s1_acy_neg_in;

   logic                 s2_vld_ff;
   tsp_pkg::seg_type     s2_seg_ff;
   logic                 s2_nx_ff, s2_ny_ff;
   logic [3:0][SQ-1:0]   s2_prod_ff;
   logic [3:0][SQ-1:0]   s2_prod_in;

   logic                 s3_vld_ff;
   tsp_pkg::seg_type     s3_seg_ff;
   logic                 s3_nx_ff, s3_ny_ff;
   logic [3:0][LOW-1:0]  s3_lo_ff, s3_hi_ff;
   logic [3:0][LOW-1:0]  s3_lo_in, s3_hi_in;

   logic                 s4_vld_ff;
   tsp_pkg::seg_type     s4_seg_ff;
   logic                 s4_nx_ff, s4_ny_ff;
   logic [3:0][PB-1:0]   s4_t_ff;
   logic [3:0][PB-1:0]   s4_t_in;

   logic                 s5_vld_ff;
   tsp_pkg::seg_type     s5_seg_ff;
   tsp_pkg::num_type     s5_num_ff, s5_den_ff;
   tsp_pkg::num_type     s5_num_in, s5_den_in;
   logic                 s5_neg_ff, s5_neg_in;

   logic                 s6_vld_ff;
   tsp_pkg::job_type     s6_job_ff;
   tsp_pkg::job_type     s6_job_in;

   // Hold requests while front plus queue hold a full queue's worth of transactions
   assign req_stall = (used_ff == USED_BITS'(tsp_pkg::FIFO_DEPTH));
   assign accept    = req_valid && !req_stall;

   always_comb begin
      used_in = used_ff;
      if (accept && !job_pop) begin
         used_in = used_ff + USED_BITS'(1);
      end else if (!accept && job_pop) begin
         used_in = used_ff - USED_BITS'(1);
      end
   end

   // Stage 1: signed deltas from start
   always_comb begin
      s1_seg_in.start_x = req_data.start_x;
      s1_seg_in.start_y = req_data.start_y;
      s1_seg_in.end_x   = req_data.end_x;
      s1_seg_in.end_y   = req_data.end_y;
      s1_seg_in.dx_neg  = req_data.end_x < req_data.start_x;
      s1_seg_in.dx_mag  = s1_seg_in.dx_neg ? req_data.start_x - req_data.end_x
                                           : req_data.end_x - req_data.start_x;
      s1_seg_in.dy_neg  = req_data.end_y < req_data.start_y;
      s1_seg_in.dy_mag  = s1_seg_in.dy_neg ? req_data.start_y - req_data.end_y
                                           : req_data.end_y - req_data.start_y;
      s1_acx_neg_in     = req_data.point_x < req_data.start_x;
      s1_acx_mag_in     = s1_acx_neg_in ? req_data.start_x - req_data.point_x
                                        : req_data.point_x - req_data.start_x;
      s1_acy_neg_in     = req_data.point_y < req_data.start_y;
      s1_acy_mag_in     = s1_acy_neg_in ? req_data.start_y - req_data.point_y
                                        : req_data.point_y - req_data.start_y;
   end

   // Stage 2: coordinate products (dot terms, then squared lengths)
   always_comb begin
      s2_prod_in[0] = SQ'(s1_seg_ff.dx_mag) * SQ'(s1_acx_mag_ff);
      s2_prod_in[1] = SQ'(s1_seg_ff.dy_mag) * SQ'(s1_acy_mag_ff);
      s2_prod_in[2] = SQ'(s1_seg_ff.dx_mag) * SQ'(s1_seg_ff.dx_mag);
      s2_prod_in[3] = SQ'(s1_seg_ff.dy_mag) * SQ'(s1_seg_ff.dy_mag);
   end

   // Stage 3: weight each product in two 32-bit halves
   always_comb begin
      logic [63:0]           p;
      tsp_pkg::weight_type   w;
      for (int i = 0; i < 4; i++) begin
         p           = 64'(s2_prod_ff[i]);
         w           = (i == 0 || i == 2) ? weight_x : weight_y;
         s3_lo_in[i] = LOW'(p[31:0]) * LOW'(w);
         s3_hi_in[i] = LOW'(p[63:32]) * LOW'(w);
      end
   end

   // Stage 4: merge halves
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         s4_t_in[i] = PB'((WIDE'(s3_hi_ff[i]) << 32) + WIDE'(s3_lo_ff[i]));
      end
   end

   // Stage 5: signed numerator as sign and magnitude, and denominator
   always_comb begin
      s5_den_in = NB'(s4_t_ff[2]) + NB'(s4_t_ff[3]);
      if (s4_nx_ff == s4_ny_ff) begin
         s5_num_in = NB'(s4_t_ff[0]) + NB'(s4_t_ff[1]);
         s5_neg_in = s4_nx_ff;
      end else if (s4_t_ff[0] >= s4_t_ff[1]) begin
         s5_num_in = NB'(s4_t_ff[0] - s4_t_ff[1]);
         s5_neg_in = s4_nx_ff;
      end else begin
         s5_num_in = NB'(s4_t_ff[1] - s4_t_ff[0]);
         s5_neg_in = s4_ny_ff;
      end
   end

   // Stage 6: classify clamp case
   always_comb begin
      s6_job_in.seg = s5_seg_ff;
      s6_job_in.num = s5_num_ff;
      s6_job_in.den = s5_den_ff;
      if (s5_neg_ff && s5_num_ff != '0) begin
         s6_job_in.kind = tsp_pkg::KIND_START;
      end else if (s5_num_ff >= s5_den_ff) begin
         s6_job_in.kind = tsp_pkg::KIND_END;
      end else begin
         s6_job_in.kind = tsp_pkg::KIND_INTERIOR;
      end
   end

   // Advance valid bits and credit count
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff   <= '0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
      end else begin
         used_ff   <= used_in;
         s1_vld_ff <= accept;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
         s6_vld_ff <= s5_vld_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      s1_seg_ff     <= s1_seg_in;
      s1_acx_mag_ff <= s1_acx_mag_in;
      s1_acy_mag_ff <= s1_acy_mag_in;
      s1_acx_neg_ff <= s1_acx_neg_in;
      s1_acy_neg_ff <= s1_acy_neg_in;
      s2_seg_ff     <= s1_seg_ff;
      s2_nx_ff      <= s1_seg_ff.dx_neg ^ s1_acx_neg_ff;
      s2_ny_ff      <= s1_seg_ff.dy_neg ^ s1_acy_neg_ff;
      s2_prod_ff    <= s2_prod_in;
      s3_seg_ff     <= s2_seg_ff;
      s3_nx_ff      <= s2_nx_ff;
      s3_ny_ff      <= s2_ny_ff;
      s3_lo_ff      <= s3_lo_in;
      s3_hi_ff      <= s3_hi_in;
      s4_seg_ff     <= s3_seg_ff;
      s4_nx_ff      <= s3_nx_ff;
      s4_ny_ff      <= s3_ny_ff;
      s4_t_ff       <= s4_t_in;
      s5_seg_ff     <= s4_seg_ff;
      s5_num_ff     <= s5_num_in;
      s5_den_ff     <= s5_den_in;
      s5_neg_ff     <= s5_neg_in;
      s6_job_ff     <= s6_job_in;
   end

   assign job_valid = s6_vld_ff;
   assign job_data  = s6_job_ff;

   `ASSERT_IMPLIES(a_stage_order, s6_vld_ff, $past(s5_vld_ff), "stage 6 valid without stage 5")
   `ASSERT_ALWAYS(a_credit_bound, used_ff <= USED_BITS'(tsp_pkg::FIFO_DEPTH), "credit count overrun")

endmodule

// ===== sv/tsp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module tsp_div (
   input  logic                 clock,
   input  logic                 adv,
   input  tsp_pkg::num_type     div_hi,
   input  tsp_pkg::coord_type   div_lo,
   input  tsp_pkg::num_type     div_den,
   output tsp_pkg::coord_type   div_quot
);

   localparam int C  = tsp_pkg::COORD_BITS;
   localparam int NB = tsp_pkg::NUM_BITS;

   tsp_pkg::num_type   rem_ff [C];
   tsp_pkg::coord_type lo_ff  [C];
   tsp_pkg::num_type   den_ff [C];
   tsp_pkg::coord_type quo_ff [C];

   for (genvar k = 0; k < C; k++) begin : g_stage
      tsp_pkg::num_type   rem_cur;
      tsp_pkg::coord_type lo_cur;
      tsp_pkg::num_type   den_cur;
      tsp_pkg::coord_type quo_cur;
      logic [NB:0]        trial;
      logic [NB:0]        diff;
      logic               ge;

      if (k == 0) begin : g_first
         assign rem_cur = div_hi;
         assign lo_cur  = div_lo;
         assign den_cur = div_den;
         assign quo_cur = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[k-1];
         assign lo_cur  = lo_ff[k-1];
         assign den_cur = den_ff[k-1];
         assign quo_cur = quo_ff[k-1];
      end

      // Shift in the next dividend bit and subtract when it fits
      assign trial = {rem_cur, lo_cur[C-1]};
      assign ge    = trial >= {1'b0, den_cur};
      assign diff  = trial - {1'b0, den_cur};

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k] <= ge ? diff[NB-1:0] : trial[NB-1:0];
            lo_ff[k]  <= {lo_cur[C-2:0], 1'b0};
            den_ff[k] <= den_cur;
            quo_ff[k] <= {quo_cur[C-2:0], ge};
         end
      end
   end

   assign div_quot = quo_ff[C-1];

endmodule

// ===== sv/tsp_back.sv =====
// Back pipeline: scaled numerator, two dividers and result selection.
`include "assert_macros.svh"

module tsp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  tsp_pkg::job_type  job_data,
   output logic              job_pop,
   output logic              rsp_valid,
   output tsp_pkg::rsp_type  rsp_data,
   input  logic              rsp_stall
);

   localparam int C    = tsp_pkg::COORD_BITS;
   localparam int NB   = tsp_pkg::NUM_BITS;
   localparam int NCH  = tsp_pkg::NUM_CHUNKS;
   localparam int CW   = tsp_pkg::CHUNK_BITS;
   localparam int PPW  = CW + C;
   localparam int SUMW = NCH * CW + C;
   localparam int DW   = NB + C;
   localparam int LAST = C + 1;

   logic                     adv;
   logic                     rsp_valid_ff;
   tsp_pkg::rsp_type         rsp_data_ff;
   tsp_pkg::rsp_type         rsp_data_in;
   logic [LAST:0]            vld_ff;
   tsp_pkg::meta_type        meta_ff [LAST+1];

   logic [NCH-1:0][PPW-1:0]  b1_ppx_ff, b1_ppy_ff;
   logic [NCH-1:0][PPW-1:0]  b1_ppx_in, b1_ppy_in;
   tsp_pkg::num_type         b1_den_ff;

   tsp_pkg::num_type         b2_hix_ff, b2_hiy_ff;
   tsp_pkg::num_type         b2_hix_in, b2_hiy_in;
   tsp_pkg::coord_type       b2_lox_ff, b2_loy_ff;
   tsp_pkg::coord_type       b2_lox_in, b2_loy_in;
   tsp_pkg::num_type         b2_den_ff;

   tsp_pkg::coord_type       quot_x, quot_y;

   // Move the whole back pipeline when the output slot is free or being taken
   assign adv     = !rsp_valid_ff || !rsp_stall;
   assign job_pop = adv && job_valid;

   // Partial products of numerator chunks by the axis delta
   always_comb begin
      logic [NCH*CW-1:0] num_ext;
      num_ext = (NCH*CW)'(job_data.num);
      for (int j = 0; j < NCH; j++) begin
         b1_ppx_in[j] = PPW'(num_ext[j*CW +: CW]) * PPW'(job_data.seg.dx_mag);
         b1_ppy_in[j] = PPW'(num_ext[j*CW +: CW]) * PPW'(job_data.seg.dy_mag);
      end
   end

   // Sum partial products and split the dividend
   always_comb begin
      logic [SUMW-1:0] acc_x;
      logic [SUMW-1:0] acc_y;
      acc_x = '0;
      acc_y = '0;
      for (int j = 0; j < NCH; j++) begin
         acc_x = acc_x + (SUMW'(b1_ppx_ff[j]) << (CW * j));
         acc_y = acc_y + (SUMW'(b1_ppy_ff[j]) << (CW * j));
      end
      b2_hix_in = acc_x[DW-1:C];
      b2_lox_in = acc_x[C-1:0];
      b2_hiy_in = acc_y[DW-1:C];
      b2_loy_in = acc_y[C-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b1_ppx_ff <= b1_ppx_in;
         b1_ppy_ff <= b1_ppy_in;
         b1_den_ff <= job_data.den;
         b2_hix_ff <= b2_hix_in;
         b2_lox_ff <= b2_lox_in;
         b2_hiy_ff <= b2_hiy_in;
         b2_loy_ff <= b2_loy_in;
         b2_den_ff <= b1_den_ff;
      end
   end

   tsp_div u_div_x (
      .clock    (clock),
      .adv      (adv),
      .div_hi   (b2_hix_ff),
      .div_lo   (b2_lox_ff),
      .div_den  (b2_den_ff),
      .div_quot (quot_x)
   );

   tsp_div u_div_y (
      .clock    (clock),
      .adv      (adv),
      .div_hi   (b2_hiy_ff),
      .div_lo   (b2_loy_ff),
      .div_den  (b2_den_ff),
      .div_quot (quot_y)
   );

   // Carry segment data and clamp kind alongside the dividers
   always_ff @(posedge clock) begin
      if (adv) begin
         meta_ff[0].seg  <= job_data.seg;
         meta_ff[0].kind <= job_data.kind;
         for (int k = 1; k <= LAST; k++) begin
            meta_ff[k] <= meta_ff[k-1];
         end
      end
   end

   // Select clamped endpoint or offset start point
   always_comb begin
      rsp_data_in.clamp_kind = meta_ff[LAST].kind;
      case (meta_ff[LAST].kind)
         tsp_pkg::KIND_START: begin
            rsp_data_in.proj_x = meta_ff[LAST].seg.start_x;
            rsp_data_in.proj_y = meta_ff[LAST].seg.start_y;
         end
         tsp_pkg::KIND_END: begin
            rsp_data_in.proj_x = meta_ff[LAST].seg.end_x;
            rsp_data_in.proj_y = meta_ff[LAST].seg.end_y;
         end
         default: begin
            rsp_data_in.proj_x = meta_ff[LAST].seg.dx_neg
                                 ? meta_ff[LAST].seg.start_x - quot_x
                                 : meta_ff[LAST].seg.start_x + quot_x;
            rsp_data_in.proj_y = meta_ff[LAST].seg.dy_neg
                                 ? meta_ff[LAST].seg.start_y - quot_y
                                 : meta_ff[LAST].seg.start_y + quot_y;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[LAST-1:0], job_valid};
         rsp_valid_ff <= vld_ff[LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_NEXT(a_result_lands, adv && vld_ff[LAST], rsp_valid_ff, "finished transaction lost")

endmodule

// ===== sv/tile_segment_projection.sv =====
// Throughput: one transaction per cycle unless req_stall or rsp_stall holds the flow;
// the divider spends one pipeline stage per quotient bit, and the classification front
// and the back are parted by an 8-entry queue.
// Reset (synchronous, active high) empties all pipelines and the queue and loads
// weight_x with 12100 and weight_y with 34708.
module tile_segment_projection (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  tsp_pkg::req_type               req_data,
   output logic                           req_stall,
   output logic                           rsp_valid,
   output tsp_pkg::rsp_type               rsp_data,
   input  logic                           rsp_stall,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  tsp_pkg::csr_index_type         csr_index,
   input  tsp_pkg::weight_type            csr_wdata
);

   tsp_pkg::weight_type weight_x_ff;
   tsp_pkg::weight_type weight_y_ff;
   logic                front_valid;
   tsp_pkg::job_type    front_data;
   logic                head_valid;
   tsp_pkg::job_type    head_data;
   logic                job_pop;

   assign csr_ready = 1'b1;

   // Write weight registers; drop writes to unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         weight_x_ff <= tsp_pkg::WEIGHT_X_RESET;
         weight_y_ff <= tsp_pkg::WEIGHT_Y_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tsp_pkg::CSR_WEIGHT_X: weight_x_ff <= csr_wdata;
            tsp_pkg::CSR_WEIGHT_Y: weight_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   tsp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .weight_x  (weight_x_ff),
      .weight_y  (weight_y_ff),
      .job_pop   (job_pop),
      .job_valid (front_valid),
      .job_data  (front_data)
   );

   tsp_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_data  (front_data),
      .pop        (job_pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   tsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (head_valid),
      .job_data  (head_data),
      .job_pop   (job_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the tile segment projection block.
module testbench;

   localparam int                 LATENCY    = tsp_pkg::COORD_BITS + 9;
   localparam int                 IDLE_LIMIT = 20000;
   localparam int                 NUM_RANDOM = 900;
   localparam tsp_pkg::coord_type CMAX       = '1;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   tsp_pkg::req_type       req_data = '0;
   logic                   req_stall;
   logic                   rsp_valid;
   tsp_pkg::rsp_type       rsp_data;
   logic                   rsp_stall = 1'b0;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   tsp_pkg::csr_index_type csr_index = tsp_pkg::CSR_WEIGHT_X;
   tsp_pkg::weight_type    csr_wdata = '0;

   // Weights as the predictor sees them
   tsp_pkg::weight_type    wx_model, wy_model;
   tsp_pkg::rsp_type       expected_q[$];
   int                     error_count = 0;
   int                     idle_cycles = 0;

   // Directed table: a typed-in result only where it is obvious
   typedef struct {
      tsp_pkg::req_type req;
      logic             known;
      tsp_pkg::rsp_type rsp;
   } vector_type;
   vector_type directed[$];

   tile_segment_projection i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_data(req_data), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .rsp_stall(rsp_stall),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // Project a point onto a segment under the current weights
   function automatic tsp_pkg::rsp_type project_point(tsp_pkg::req_type r);
      logic signed [33:0]  abx, aby, acx, acy;
      logic signed [127:0] num, den, qx, qy;
      tsp_pkg::rsp_type    res;
      abx = $signed({3'b0, r.end_x}) - $signed({3'b0, r.start_x});
      aby = $signed({3'b0, r.end_y}) - $signed({3'b0, r.start_y});
      acx = $signed({3'b0, r.point_x}) - $signed({3'b0, r.start_x});
      acy = $signed({3'b0, r.point_y}) - $signed({3'b0, r.start_y});
      num = 128'(abx) * 128'(acx) * $signed({1'b0, wx_model})
          + 128'(aby) * 128'(acy) * $signed({1'b0, wy_model});
      den = 128'(abx) * 128'(abx) * $signed({1'b0, wx_model})
          + 128'(aby) * 128'(aby) * $signed({1'b0, wy_model});
      if (num < 0) begin
         res.proj_x = r.start_x;
         res.proj_y = r.start_y;
         res.clamp_kind = tsp_pkg::KIND_START;
      end else if (num >= den) begin
         res.proj_x = r.end_x;
         res.proj_y = r.end_y;
         res.clamp_kind = tsp_pkg::KIND_END;
      end else begin
         // signed division truncates toward zero
         qx = (128'(abx) * num) / den;
         qy = (128'(aby) * num) / den;
         res.proj_x = tsp_pkg::coord_type'(128'(r.start_x) + qx);
         res.proj_y = tsp_pkg::coord_type'(128'(r.start_y) + qy);
         res.clamp_kind = tsp_pkg::KIND_INTERIOR;
      end
      return res;
   endfunction

   function automatic tsp_pkg::coord_type rand_coord();
      case ($urandom_range(0, 3))
         0: return tsp_pkg::coord_type'($urandom);
         1: return tsp_pkg::coord_type'($urandom_range(0, 1000));
         2: return CMAX - tsp_pkg::coord_type'($urandom_range(0, 1000));
         default: return tsp_pkg::coord_type'(32'h4000_0000 + $urandom_range(0, 65535));
      endcase
   endfunction

   // Random query: mostly points near the segment, sometimes degenerate
   function automatic tsp_pkg::req_type rand_request();
      tsp_pkg::req_type r;
      r.start_x = rand_coord();
      r.start_y = rand_coord();
      if ($urandom_range(0, 15) == 0) begin
         r.end_x = r.start_x;
         r.end_y = r.start_y;
      end else begin
         r.end_x = rand_coord();
         r.end_y = rand_coord();
      end
      if ($urandom_range(0, 2) == 0) begin
         r.point_x = rand_coord();
         r.point_y = rand_coord();
      end else begin
         r.point_x = (r.start_x >> 1) + (r.end_x >> 1)
                   + tsp_pkg::coord_type'($urandom_range(0, 255));
         r.point_y = (r.start_y >> 1) + (r.end_y >> 1)
                   + tsp_pkg::coord_type'($urandom_range(0, 255));
      end
      return r;
   endfunction

   function automatic tsp_pkg::req_type make_req(tsp_pkg::coord_type px,
                                                 tsp_pkg::coord_type py,
                                                 tsp_pkg::coord_type sx,
                                                 tsp_pkg::coord_type sy,
                                                 tsp_pkg::coord_type ex,
                                                 tsp_pkg::coord_type ey);
      tsp_pkg::req_type r;
      r.point_x = px; r.point_y = py;
      r.start_x = sx; r.start_y = sy;
      r.end_x = ex; r.end_y = ey;
      return r;
   endfunction

   function automatic tsp_pkg::rsp_type make_rsp(tsp_pkg::coord_type x, tsp_pkg::coord_type y,
                                                 tsp_pkg::kind_type k);
      tsp_pkg::rsp_type r;
      r.proj_x = x; r.proj_y = y; r.clamp_kind = k;
      return r;
   endfunction

   task automatic add_row(tsp_pkg::req_type r, logic known, tsp_pkg::rsp_type rsp);
      vector_type v;
      v.req = r; v.known = known; v.rsp = rsp;
      directed.insert(directed.size(), v);
   endtask

   // Send one transaction; hold it until an edge with the stall low
   task automatic send_request(tsp_pkg::req_type r, tsp_pkg::rsp_type want);
      req_valid <= 1'b1;
      req_data  <= r;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
      expected_q.insert(expected_q.size(), want);
   endtask

   task automatic drop_valid();
      req_valid <= 1'b0;
   endtask

   task automatic write_weight(tsp_pkg::csr_index_type idx, tsp_pkg::weight_type value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      if (idx == tsp_pkg::CSR_WEIGHT_X) wx_model = value;
      else if (idx == tsp_pkg::CSR_WEIGHT_Y) wy_model = value;
   endtask

   // Let everything drain, then allow for the pipeline depth
   task automatic drain();
      while (expected_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   // Receiver: stall on a pattern of its own
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else case ((idle_cycles ^ $urandom) & 32'h7)
         0, 1, 2: rsp_stall <= ($urandom_range(0, 63) < 40);
         default: rsp_stall <= 1'b0;
      endcase
   end

   // Check each accepted result against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result %p", $realtime, rsp_data);
            error_count++;
         end else begin
            tsp_pkg::rsp_type want;
            want = expected_q.pop_front();
            if (rsp_data.proj_x !== want.proj_x)
               $display("%0t: proj_x expected %0d actual %0d", $realtime, want.proj_x,
                        rsp_data.proj_x);
            if (rsp_data.proj_y !== want.proj_y)
               $display("%0t: proj_y expected %0d actual %0d", $realtime, want.proj_y,
                        rsp_data.proj_y);
            if (rsp_data.clamp_kind !== want.clamp_kind)
               $display("%0t: clamp_kind expected %0d actual %0d", $realtime,
                        want.clamp_kind, rsp_data.clamp_kind);
            if (rsp_data !== want) error_count++;
         end
      end
   end

   // Watchdog on cycles with no transaction
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Run a stream of random queries in bursts
   task automatic random_phase(int count);
      int burst;
      tsp_pkg::req_type r;
      while (count > 0) begin
         burst = $urandom_range(1, 24);
         while (burst > 0 && count > 0) begin
            r = rand_request();
            send_request(r, project_point(r));
            burst--;
            count--;
         end
         if ($urandom_range(0, 3) != 0) begin
            drop_valid();
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
      drop_valid();
   endtask

   initial begin
      tsp_pkg::rsp_type want;
      wx_model = tsp_pkg::WEIGHT_X_RESET;
      wy_model = tsp_pkg::WEIGHT_Y_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows: clamps, degenerate segments, extremes, interior
      add_row(make_req(0, 0, 0, 0, 0, 0), 1, make_rsp(0, 0, tsp_pkg::KIND_END));
      add_row(make_req(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX), 1,
              make_rsp(CMAX, CMAX, tsp_pkg::KIND_END));
      add_row(make_req(5, 5, 100, 100, 100, 100), 1, make_rsp(100, 100, tsp_pkg::KIND_END));
      add_row(make_req(0, 0, 10, 10, 20, 20), 1, make_rsp(10, 10, tsp_pkg::KIND_START));
      add_row(make_req(CMAX, CMAX, 10, 10, 20, 20), 1, make_rsp(20, 20, tsp_pkg::KIND_END));
      add_row(make_req(0, 0, CMAX, CMAX, 0, 0), 1, make_rsp(0, 0, tsp_pkg::KIND_END));
      // Point on the start: zero numerator stays interior
      add_row(make_req(CMAX, CMAX, CMAX, CMAX, 0, 0), 1,
              make_rsp(CMAX, CMAX, tsp_pkg::KIND_INTERIOR));
      add_row(make_req(CMAX, 0, 0, CMAX, CMAX, 0), 1, make_rsp(CMAX, 0, tsp_pkg::KIND_END));
      add_row(make_req(0, CMAX, 0, CMAX, CMAX, 0), 1,
              make_rsp(0, CMAX, tsp_pkg::KIND_INTERIOR));
      add_row(make_req(15, 0, 10, 10, 20, 10), 1, make_rsp(15, 10, tsp_pkg::KIND_INTERIOR));
      add_row(make_req(20, 10, 10, 10, 20, 10), 1, make_rsp(20, 10, tsp_pkg::KIND_END));
      add_row(make_req(10, 99, 10, 10, 20, 10), 1, make_rsp(10, 10, tsp_pkg::KIND_INTERIOR));
      add_row(make_req(CMAX >> 1, 7, 0, 0, CMAX, CMAX), 0, '0);
      add_row(make_req(3, CMAX, CMAX, 0, 0, CMAX), 0, '0);
      add_row(make_req(12345, 67890, 0, 100000, 200000, 0), 0, '0);
      add_row(make_req(CMAX - 3, 2, CMAX, 1, 1, CMAX), 0, '0);
      add_row(make_req(31'h2AAA_AAAA, 31'h5555_5555, 31'h5555_5555, 31'h2AAA_AAAA,
                       31'h2AAA_AAAA, 31'h5555_5555), 0, '0);
      foreach (directed[i]) begin
         want = directed[i].known ? directed[i].rsp : project_point(directed[i].req);
         send_request(directed[i].req, want);
      end
      drop_valid();
      drain();

      // Weight settings, extremes among them
      random_phase(200);
      drain();
      write_weight(tsp_pkg::CSR_WEIGHT_X, 16'd1);
      write_weight(tsp_pkg::CSR_WEIGHT_Y, 16'hFFFF);
      random_phase(175);
      drain();
      write_weight(tsp_pkg::CSR_WEIGHT_X, 16'hFFFF);
      write_weight(tsp_pkg::CSR_WEIGHT_Y, 16'd1);
      random_phase(175);
      drain();
      write_weight(tsp_pkg::CSR_WEIGHT_X, 16'hFFFF);
      write_weight(tsp_pkg::CSR_WEIGHT_Y, 16'hFFFF);
      random_phase(175);
      drain();
      write_weight(tsp_pkg::CSR_WEIGHT_X, tsp_pkg::weight_type'($urandom));
      write_weight(tsp_pkg::CSR_WEIGHT_Y, tsp_pkg::weight_type'($urandom));
      random_phase(175);
      drain();

      if (error_count == 0 && expected_q.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
